### sv/spcp_pkg.sv
// Shared constants, types and status codes of the serial PWM command parser.
package spcp_pkg;

  localparam int LineLength = 64;
  localparam int ValueBits  = 16;
  localparam int CountW     = $clog2(LineLength);
  localparam int StatusW    = 3;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChW     = 8'h77;
  localparam logic [7:0] ChM     = 8'h6d;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChQ     = 8'h71;

  typedef enum logic [StatusW-1:0] {
    StPwmSet   = 3'd0,
    StFreqSet  = 3'd1,
    StBadPwm   = 3'd2,
    StBadFreq  = 3'd3,
    StUnknown  = 3'd4,
    StOverflow = 3'd5
  } status_e;

  typedef struct packed {
    logic                 valid;
    status_e              status;
    logic [ValueBits-1:0] number;
  } result_t;

endpackage

### sv/spcp_if.sv
// Valid/ready channel interfaces for received characters and parse results.
interface spcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface spcp_out_if;
  logic                          valid;
  logic                          ready;
  logic [spcp_pkg::StatusW-1:0]  status;
  logic [spcp_pkg::ValueBits-1:0] number;

  modport source (output valid, output status, output number, input ready);
  modport sink (input valid, input status, input number, output ready);
endinterface

### sv/spcp_parse.sv
// Per-character command parser: line state registers and result decode.
module spcp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        ch_i,
  output spcp_pkg::result_t res_o
);

  localparam logic [1:0] PhLead    = 2'd0;
  localparam logic [1:0] PhPrefix  = 2'd1;
  localparam logic [1:0] PhDigits  = 2'd2;
  localparam logic [1:0] PhUnknown = 2'd3;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindPwm  = 2'd1;
  localparam logic [1:0] KindFreq = 2'd2;

  localparam int AccW = spcp_pkg::ValueBits;
  localparam int WideW = AccW + 4;

  function automatic logic [7:0] want_char(logic [1:0] kind, logic [2:0] pos);
    logic [7:0] c;
    if (kind == KindPwm) begin
      case (pos[1:0])
        2'd0:    c = spcp_pkg::ChP;
        2'd1:    c = spcp_pkg::ChW;
        default: c = spcp_pkg::ChM;
      endcase
    end else begin
      case (pos[1:0])
        2'd0:    c = spcp_pkg::ChF;
        2'd1:    c = spcp_pkg::ChR;
        2'd2:    c = spcp_pkg::ChE;
        default: c = spcp_pkg::ChQ;
      endcase
    end
    return c;
  endfunction

  logic [spcp_pkg::CountW-1:0] count_q, count_d;
  logic [1:0]                  phase_q, phase_d;
  logic [2:0]                  pos_q, pos_d;
  logic [1:0]                  kind_q, kind_d;
  logic [AccW-1:0]             acc_q, acc_d;
  logic                        bad_q, bad_d;

  logic [2:0]       prefix_len;
  logic             is_digit;
  logic [WideW-1:0] wide;

  assign prefix_len = (kind_q == KindPwm) ? 3'd3 : 3'd4;
  assign is_digit   = (ch_i >= spcp_pkg::ChZero) && (ch_i <= spcp_pkg::ChNine);
  assign wide       = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                    + WideW'(ch_i - spcp_pkg::ChZero);

  always_comb begin
    count_d = count_q;
    phase_d = phase_q;
    pos_d   = pos_q;
    kind_d  = kind_q;
    acc_d   = acc_q;
    bad_d   = bad_q;
    res_o.valid  = 1'b0;
    res_o.status = spcp_pkg::StUnknown;
    res_o.number = '0;

    if (valid_i && ch_i != spcp_pkg::ChCr && ch_i != spcp_pkg::ChLf) begin
      if (ch_i == spcp_pkg::ChSemi) begin
        res_o.valid = 1'b1;
        if (phase_q == PhDigits && kind_q == KindPwm) begin
          res_o.status = bad_q ? spcp_pkg::StBadPwm : spcp_pkg::StPwmSet;
          res_o.number = bad_q ? '0 : acc_q;
        end else if (phase_q == PhDigits && kind_q == KindFreq) begin
          res_o.status = bad_q ? spcp_pkg::StBadFreq : spcp_pkg::StFreqSet;
          res_o.number = bad_q ? '0 : acc_q;
        end
        count_d = '0;
        phase_d = PhLead;
        pos_d   = '0;
        kind_d  = KindNone;
        acc_d   = '0;
        bad_d   = 1'b0;
      end else begin
        unique case (phase_q)
          PhLead: begin
            if (ch_i == spcp_pkg::ChP) begin
              kind_d  = KindPwm;
              pos_d   = 3'd1;
              phase_d = PhPrefix;
            end else if (ch_i == spcp_pkg::ChF) begin
              kind_d  = KindFreq;
              pos_d   = 3'd1;
              phase_d = PhPrefix;
            end else if (ch_i != spcp_pkg::ChSpace) begin
              phase_d = PhUnknown;
            end
          end
          PhPrefix: begin
            if (pos_q < prefix_len && ch_i == want_char(kind_q, pos_q)) begin
              pos_d = pos_q + 3'd1;
              if (pos_d == prefix_len) begin
                phase_d = PhDigits;
              end
            end else begin
              phase_d = PhUnknown;
            end
          end
          PhDigits: begin
            if (is_digit) begin
              if (!bad_q) begin
                if (|wide[WideW-1:AccW]) begin
                  acc_d = '1;
                  bad_d = 1'b1;
                end else begin
                  acc_d = wide[AccW-1:0];
                end
              end
            end else begin
              bad_d = 1'b1;
            end
          end
          default: begin
          end
        endcase

        count_d = count_q + 1'b1;
        if (count_q == spcp_pkg::CountW'(spcp_pkg::LineLength - 1)) begin
          res_o.valid  = 1'b1;
          res_o.status = spcp_pkg::StOverflow;
          count_d = '0;
          phase_d = PhLead;
          pos_d   = '0;
          kind_d  = KindNone;
          acc_d   = '0;
          bad_d   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= PhLead;
      pos_q   <= '0;
      kind_q  <= KindNone;
      acc_q   <= '0;
      bad_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      kind_q  <= kind_d;
      acc_q   <= acc_d;
      bad_q   <= bad_d;
    end
  end

  a_digits_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDigits |-> kind_q != KindNone)
    else $error("digit phase without a command kind");

  a_semi_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ch_i == spcp_pkg::ChSemi) |-> res_o.valid)
    else $error("terminator gave no result");

  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> (count_q == '0 && phase_q == PhLead && !bad_q))
    else $error("line state not cleared after result");

endmodule

### sv/serial_pwm_command_parser.sv
// The result of the beat that ends a line is registered in the output buffer.
// Throughput: one character beat per cycle while results are taken.
// A two-entry output buffer lets characters keep flowing while one result waits.
// Ready drops only when both output entries hold results.
// Reset: parser returns to the leading-space phase, empty line, output buffer empty.
module serial_pwm_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  spcp_in_if.sink     cmd_i,
  spcp_out_if.source  res_o
);

  spcp_pkg::result_t res;
  spcp_pkg::result_t head_q, head_d, skid_q, skid_d;
  logic              head_valid_q, head_valid_d, skid_valid_q, skid_valid_d;
  logic              accept, push, pop;

  assign cmd_i.ready = !skid_valid_q;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign push        = res.valid;
  assign pop         = head_valid_q && res_o.ready;

  spcp_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .ch_i    (cmd_i.ch),
    .res_o   (res)
  );

  always_comb begin
    head_d       = head_q;
    skid_d       = skid_q;
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    if (!head_valid_q) begin
      head_d       = res;
      head_valid_d = push;
    end else if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_d       = res;
        skid_valid_d = push;
      end else begin
        head_d       = res;
        head_valid_d = push;
      end
    end else if (push) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign res_o.valid  = head_valid_q;
  assign res_o.status = head_q.status;
  assign res_o.number = head_q.number;

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> head_valid_q)
    else $error("skid entry held with empty head");

  a_number_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_q && head_q.status != spcp_pkg::StPwmSet
     && head_q.status != spcp_pkg::StFreqSet) |-> head_q.number == '0)
    else $error("nonzero number on a failure status");

  a_semi_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.ch == spcp_pkg::ChSemi) |=> head_valid_q)
    else $error("terminator beat lost");

endmodule

### bench/tb.sv
// Self-checking testbench for serial_pwm_command_parser: directed and random command lines.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ValueMax   = (1 << spcp_pkg::ValueBits) - 1;
  localparam int unsigned QuietLimit = 1000;

  typedef enum logic [1:0] {PhLead, PhPrefix, PhDigits, PhJunk} phase_e;
  typedef enum logic [1:0] {KindNone, KindPwm, KindFreq} kind_e;

  typedef struct packed {
    spcp_pkg::status_e              status;
    logic [spcp_pkg::ValueBits-1:0] number;
  } outcome_t;

  logic clk;
  logic rst_n;

  spcp_in_if  cmd_if ();
  spcp_out_if res_if ();

  serial_pwm_command_parser dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if.sink),
    .res_o  (res_if.source)
  );

  // parser shadow state
  int unsigned line_chars;
  phase_e      phase;
  int unsigned prefix_pos;
  kind_e       kind;
  int unsigned accum;
  bit          value_bad;

  outcome_t    expected_results[$];
  int unsigned errors;
  int unsigned chars_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_line_state();
    line_chars = 0;
    phase      = PhLead;
    prefix_pos = 0;
    kind       = KindNone;
    accum      = 0;
    value_bad  = 1'b0;
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    string       word;
    int unsigned v;
    case (phase)
      PhLead: begin
        if (c == spcp_pkg::ChP) begin
          kind = KindPwm;
          prefix_pos = 1;
          phase = PhPrefix;
        end else if (c == spcp_pkg::ChF) begin
          kind = KindFreq;
          prefix_pos = 1;
          phase = PhPrefix;
        end else if (c != spcp_pkg::ChSpace) begin
          phase = PhJunk;
        end
      end
      PhPrefix: begin
        word = (kind == KindPwm) ? "pwm" : "freq";
        if (prefix_pos < word.len() && word[prefix_pos] == c) begin
          prefix_pos++;
          if (prefix_pos == word.len()) phase = PhDigits;
        end else begin
          phase = PhJunk;
        end
      end
      PhDigits: begin
        if (c >= spcp_pkg::ChZero && c <= spcp_pkg::ChNine) begin
          if (!value_bad) begin
            v = accum * 10 + (c - spcp_pkg::ChZero);
            if (v > ValueMax) begin
              v = ValueMax;
              value_bad = 1'b1;
            end
            accum = v;
          end
        end else begin
          value_bad = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_char(input logic [7:0] c);
    outcome_t o;
    if (c == spcp_pkg::ChCr || c == spcp_pkg::ChLf) return;
    o.number = '0;
    if (c == spcp_pkg::ChSemi) begin
      if (phase == PhDigits && kind == KindPwm) begin
        o.status = value_bad ? spcp_pkg::StBadPwm : spcp_pkg::StPwmSet;
        if (!value_bad) o.number = accum[spcp_pkg::ValueBits-1:0];
      end else if (phase == PhDigits && kind == KindFreq) begin
        o.status = value_bad ? spcp_pkg::StBadFreq : spcp_pkg::StFreqSet;
        if (!value_bad) o.number = accum[spcp_pkg::ValueBits-1:0];
      end else begin
        o.status = spcp_pkg::StUnknown;
      end
      clear_line_state();
      expected_results.push_back(o);
      return;
    end
    absorb_char(c);
    line_chars++;
    if (line_chars >= spcp_pkg::LineLength) begin
      clear_line_state();
      o.status = spcp_pkg::StOverflow;
      expected_results.push_back(o);
    end
  endfunction

  function automatic void check_result();
    outcome_t o;
    if (expected_results.size() == 0) begin
      $error("unexpected result: status %0d number %0d", res_if.status, res_if.number);
      errors++;
      return;
    end
    o = expected_results.pop_front();
    if (res_if.status !== o.status) begin
      $error("status: expected %0d, got %0d", o.status, res_if.status);
      errors++;
    end
    if (res_if.number !== o.number) begin
      $error("number: expected %0d, got %0d", o.number, res_if.number);
      errors++;
    end
  endfunction

  // results are checked before the same edge's character beat is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready) check_result();
      if (cmd_if.valid && cmd_if.ready) predict_char(cmd_if.ch);
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.ch    <= c;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  function automatic void push_text(ref logic [7:0] q[$], input string s);
    foreach (s[i]) q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] bad_byte();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return "-";
      2: return spcp_pkg::ChSpace;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_line();
    logic [7:0]  q[$];
    int unsigned pick;
    int unsigned n;
    int unsigned v;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 70) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) q.push_back(spcp_pkg::ChSpace);
      push_text(q, $urandom_range(1) ? "pwm" : "freq");
      case ($urandom_range(5))
        0: v = $urandom_range(9);
        1: v = $urandom_range(ValueMax);
        2: v = $urandom_range(ValueMax - 5, ValueMax + 5);
        3: v = $urandom_range(ValueMax + 1, 999999);
        4: v = $urandom_range(999);
        default: v = $urandom_range(99999);
      endcase
      n = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) q.push_back(spcp_pkg::ChZero);
      if ($urandom_range(9) != 0) push_text(q, $sformatf("%0d", v));
      if (pick >= 55) q[$urandom_range(q.size() - 1)] = bad_byte();
    end else if (pick < 85) begin
      n = $urandom_range(1, 8);
      repeat (n) q.push_back(8'($urandom_range(255)));
    end else begin
      // long line, mostly past the overflow point
      if ($urandom_range(1)) push_text(q, "pwm");
      n = $urandom_range(58, 70);
      repeat (n) begin
        case ($urandom_range(2))
          0: b = spcp_pkg::ChZero + 8'($urandom_range(9));
          1: b = spcp_pkg::ChSpace;
          default: b = 8'($urandom_range(255));
        endcase
        q.push_back((b == spcp_pkg::ChSemi) ? spcp_pkg::ChSpace : b);
      end
    end
    q.push_back(spcp_pkg::ChSemi);
    foreach (q[i]) begin
      if ($urandom_range(24) == 0) begin
        send_char($urandom_range(1) ? spcp_pkg::ChCr : spcp_pkg::ChLf);
      end
      send_char(q[i]);
    end
  endtask

  task automatic test_set_commands();
    send_text("pwm65535;");
    send_text("freq;");
  endtask

  task automatic test_malformed_lines();
    send_text(" \r\nf;");
    send_text("pwm-;");
    send_text(";");
  endtask

  task automatic test_random_commands(input int unsigned n_chars, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
    int unsigned stop_at;
    stop_at        = chars_sent + n_chars;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (chars_sent < stop_at) send_random_line();
  endtask

  initial begin
    errors         = 0;
    chars_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    clear_line_state();
    rst_n        <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.ch    <= 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_set_commands();
    test_malformed_lines();
    test_random_commands(350, 0, 0);
    test_random_commands(350, 54, 0);
    test_random_commands(350, 0, 54);
    test_random_commands(350, 27, 27);

    cmd_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/spcp_pkg.sv
sv/spcp_if.sv
sv/spcp_parse.sv
sv/serial_pwm_command_parser.sv
bench/tb.sv
